### rtl/timed_event_dispatch_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Timed event dispatch queue - assertion macros
// Clocked assertion helpers used by the queue sequencer.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_DISPATCH_QUEUE_CORE_MACROS_SVH
`define TIMED_EVENT_DISPATCH_QUEUE_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TEDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication, checked out of reset.
`define TEDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/tedq_pkg.sv
// ----------------------------------------------------------------------------
// Timed event dispatch queue package
// Sizes, command codes and payload types shared by the queue RTL.
// ----------------------------------------------------------------------------
package tedq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_RESULTS = 64;

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] time_value;
    logic [15:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [15:0] fired_handle;
    logic        fired;
    logic        status;
    logic        last;
  } out_item_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [31:0] due_time;
    logic [15:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

endpackage

### rtl/tedq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tedq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tedq_ctrl.sv
// ----------------------------------------------------------------------------
// Timed event dispatch queue - sequencer
// Walks the event RAM for sorted insert and for firing due events.
// ----------------------------------------------------------------------------
`include "timed_event_dispatch_queue_core_macros.svh"

module tedq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tedq_pkg::in_item_t           in_data,
  input  logic                         out_free,
  output tedq_pkg::res_push_t          res,
  output logic                         wr_en,
  output logic [tedq_pkg::ADDR_W-1:0]  wr_addr,
  output logic [tedq_pkg::ENTRY_W-1:0] wr_data,
  output logic                         rd_en,
  output logic [tedq_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [tedq_pkg::ENTRY_W-1:0] rd_data
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ADD_CMP  = 6'b000010,
    ST_ADD_PUT  = 6'b000100,
    ST_TICK_RD  = 6'b001000,
    ST_TICK_CMP = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  localparam tedq_pkg::out_item_t RES_OK   = '{fired_handle: 16'd0, fired: 1'b0,
                                               status: 1'b0, last: 1'b1};
  localparam tedq_pkg::out_item_t RES_FULL = '{fired_handle: 16'd0, fired: 1'b0,
                                               status: 1'b1, last: 1'b1};

  state_t                           state_r, state_nxt;
  logic [tedq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [tedq_pkg::CNT_W-1:0]       cursor_r, cursor_nxt;
  logic [tedq_pkg::ADDR_W-1:0]      idx_r, idx_nxt;
  logic [tedq_pkg::RES_CNT_W-1:0]   n_r, n_nxt;
  logic                             pend_vld_r, pend_vld_nxt;
  logic [15:0]                      pend_handle_r, pend_handle_nxt;
  tedq_pkg::out_item_t              done_r, done_nxt;
  tedq_pkg::in_item_t               req_r, req_nxt;
  tedq_pkg::entry_t                 rd_entry;
  tedq_pkg::entry_t                 new_entry;
  tedq_pkg::out_item_t              tick_end;

  assign rd_entry  = tedq_pkg::entry_t'(rd_data);
  assign new_entry = '{due_time: req_r.time_value, handle: req_r.handle};
  assign in_stall  = (state_r != ST_IDLE);

  // Final result of a tick: the held-back due event, or a nothing-due marker.
  always_comb begin
    if (pend_vld_r) begin
      tick_end = '{fired_handle: pend_handle_r, fired: 1'b1, status: 1'b0, last: 1'b1};
    end else begin
      tick_end = RES_OK;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    cursor_nxt      = cursor_r;
    idx_nxt         = idx_r;
    n_nxt           = n_r;
    pend_vld_nxt    = pend_vld_r;
    pend_handle_nxt = pend_handle_r;
    done_nxt        = done_r;
    req_nxt         = req_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = new_entry;
    rd_en           = 1'b0;
    rd_addr         = '0;
    res             = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          case (in_data.cmd)
            tedq_pkg::CMD_ADD: begin
              if (count_r >= tedq_pkg::CNT_W'(tedq_pkg::TABLE_DEPTH)) begin
                done_nxt  = RES_FULL;
                state_nxt = ST_DONE;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = tedq_pkg::entry_t'{due_time: in_data.time_value,
                                               handle: in_data.handle};
                count_nxt = count_r + tedq_pkg::CNT_W'(1);
                done_nxt  = RES_OK;
                state_nxt = ST_DONE;
              end else begin
                // scan down from the top entry, shifting later ones up
                idx_nxt   = tedq_pkg::ADDR_W'(count_r - tedq_pkg::CNT_W'(1));
                rd_en     = 1'b1;
                rd_addr   = idx_nxt;
                state_nxt = ST_ADD_CMP;
              end
            end
            tedq_pkg::CMD_TICK: begin
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_TICK_RD;
            end
            tedq_pkg::CMD_CLEAR: begin
              count_nxt  = '0;
              cursor_nxt = '0;
              done_nxt   = RES_OK;
              state_nxt  = ST_DONE;
            end
            default: begin
              done_nxt  = RES_OK;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_ADD_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + tedq_pkg::ADDR_W'(1);
        if (rd_entry.due_time > req_r.time_value) begin
          wr_data = rd_entry;
          if (idx_r == '0) begin
            state_nxt = ST_ADD_PUT;
          end else begin
            idx_nxt = idx_r - tedq_pkg::ADDR_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
          end
        end else begin
          // new entry goes right above the last one at or before its time
          wr_data   = new_entry;
          count_nxt = count_r + tedq_pkg::CNT_W'(1);
          if ((tedq_pkg::CNT_W'(idx_r) + tedq_pkg::CNT_W'(1)) < cursor_r) begin
            cursor_nxt = cursor_r + tedq_pkg::CNT_W'(1);
          end
          done_nxt  = RES_OK;
          state_nxt = ST_DONE;
        end
      end

      ST_ADD_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_entry;
        count_nxt = count_r + tedq_pkg::CNT_W'(1);
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r + tedq_pkg::CNT_W'(1);
        end
        done_nxt  = RES_OK;
        state_nxt = ST_DONE;
      end

      ST_TICK_RD: begin
        if ((cursor_r < count_r) &&
            (n_r < tedq_pkg::RES_CNT_W'(tedq_pkg::MAX_RESULTS))) begin
          rd_en     = 1'b1;
          rd_addr   = tedq_pkg::ADDR_W'(cursor_r);
          state_nxt = ST_TICK_CMP;
        end else begin
          done_nxt  = tick_end;
          state_nxt = ST_DONE;
        end
      end

      ST_TICK_CMP: begin
        if (rd_entry.due_time <= req_r.time_value) begin
          // read data holds while waiting for the output slot
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              res.valid = 1'b1;
              res.item  = '{fired_handle: pend_handle_r, fired: 1'b1,
                            status: 1'b0, last: 1'b0};
            end
            pend_vld_nxt    = 1'b1;
            pend_handle_nxt = rd_entry.handle;
            cursor_nxt      = cursor_r + tedq_pkg::CNT_W'(1);
            n_nxt           = n_r + tedq_pkg::RES_CNT_W'(1);
            state_nxt       = ST_TICK_RD;
          end
        end else begin
          done_nxt  = tick_end;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.item  = done_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      cursor_r   <= '0;
      idx_r      <= '0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      cursor_r   <= cursor_nxt;
      idx_r      <= idx_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_handle_r <= pend_handle_nxt;
    done_r        <= done_nxt;
    req_r         <= req_nxt;
  end

  `TEDQ_ASSERT(a_cursor_in_range, cursor_r <= count_r, "cursor past entry count")
  `TEDQ_ASSERT(a_count_in_range, count_r <= tedq_pkg::CNT_W'(tedq_pkg::TABLE_DEPTH), "count over depth")
  `TEDQ_ASSERT_IMPL(a_no_rw_overlap, rd_en && wr_en, rd_addr != wr_addr, "read and write same entry")
  `TEDQ_ASSERT_IMPL(a_push_when_free, res.valid, out_free, "result pushed into full output")

endmodule

### rtl/timed_event_dispatch_queue_core.sv
// ----------------------------------------------------------------------------
// Timed event dispatch queue core
// Sorted table of timed events in one RAM; add, tick and clear commands.
// ----------------------------------------------------------------------------
// Add: a full or empty table is answered without a scan; otherwise each entry
//   above the slot is shifted up, one entry per cycle; clear/unused answer directly.
// Tick: each fired event is read, then compared; the walk ends at the table end, the
//   cap or a not-due entry, then the last result; stalls stretch compares and result.
// Flow: one item in flight; the next is accepted only after its last result is pushed.
// Reset clears count, cursor and control only; never-written entries are never read.

module timed_event_dispatch_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tedq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tedq_pkg::out_item_t out_data
);

  logic                         out_valid_r;
  tedq_pkg::out_item_t          out_data_r;
  logic                         out_free;
  tedq_pkg::res_push_t          res;

  logic                         wr_en;
  logic [tedq_pkg::ADDR_W-1:0]  wr_addr;
  logic [tedq_pkg::ENTRY_W-1:0] wr_data;
  logic                         rd_en;
  logic [tedq_pkg::ADDR_W-1:0]  rd_addr;
  logic [tedq_pkg::ENTRY_W-1:0] rd_data;

  // Entry RAM: {due time, handle}, kept sorted by due time.
  tedq_ram #(
    .WIDTH (tedq_pkg::ENTRY_W),
    .DEPTH (tedq_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: sorted insert and due-event walk.
  tedq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Output register: free when empty or its result leaves on this edge.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/timed_event_dispatch_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed event dispatch queue core - testbench
// Drives add, tick, clear and unused commands through the valid/stall input,
// predicts every dispatch result with a shadow copy of the sorted event table
// and checks each result transfer field by field, under changing idle and
// stall pressure on both channels.
// ----------------------------------------------------------------------------
module timed_event_dispatch_queue_core_tb;

  // Command code the block has no meaning for; it must just answer once.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int          ITEM_GOAL   = 375;  // directed part plus random
  localparam int          PHASE_LEN   = 48;
  localparam int          PRINT_CAP   = 200;

  // Idle profile of a stretch of stimulus: who idles, and how often.
  typedef enum logic [1:0] {
    PACE_FREE,        // neither side idles
    PACE_SEND_IDLE,   // sender idles at a 63 percent chance
    PACE_RECV_STALL,  // receiver stalls at a 63 percent chance
    PACE_BOTH         // both sides, 34 percent chance each
  } pace_e;

  typedef struct {
    tedq_pkg::in_item_t item;
    pace_e              pace;
    bit                 drain;  // hold this item back until every result has come
  } stim_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tedq_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tedq_pkg::out_item_t out_data;

  timed_event_dispatch_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Stimulus waiting to be driven, and results owed by the block.
  stim_t               stim_q[$];
  tedq_pkg::out_item_t expected_q[$];

  pace_e       pace_now    = PACE_FREE;
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Shadow copy of the event table: sorted by due time, cursor at the first
  // entry not yet fired.
  logic [31:0] shadow_time   [tedq_pkg::TABLE_DEPTH];
  logic [15:0] shadow_handle [tedq_pkg::TABLE_DEPTH];
  int          shadow_count  = 0;
  int          shadow_cursor = 0;

  // Generator bookkeeping.
  pace_e       gen_pace    = PACE_FREE;
  bit          gen_drain   = 1'b0;
  int          gen_items   = 0;
  int          gen_entries = 0;
  logic [31:0] gen_now;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic logic [15:0] rand_handle();
    return 16'($urandom_range(0, 65535));
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow table and queues
  // the results it owes.
  // --------------------------------------------------------------------------
  function automatic void dispatch_command(tedq_pkg::in_item_t it);
    tedq_pkg::out_item_t r;
    int                  pos;
    int                  i;
    int                  n;
    r      = '0;
    r.last = 1'b1;
    case (it.cmd)
      tedq_pkg::CMD_ADD: begin
        if (shadow_count >= tedq_pkg::TABLE_DEPTH) begin
          r.status = 1'b1;  // table full, refused, table untouched
        end else begin
          // New entry goes after every entry of equal or earlier time.
          pos = 0;
          while (pos < shadow_count && shadow_time[pos] <= it.time_value) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_time[i]   = shadow_time[i - 1];
            shadow_handle[i] = shadow_handle[i - 1];
          end
          shadow_time[pos]   = it.time_value;
          shadow_handle[pos] = it.handle;
          shadow_count++;
          // Landing among already fired entries: it counts as fired too.
          if (pos < shadow_cursor) shadow_cursor++;
        end
        expected_q.insert(expected_q.size(), r);
      end
      tedq_pkg::CMD_TICK: begin
        n = 0;
        while (n < tedq_pkg::MAX_RESULTS && shadow_cursor < shadow_count &&
               shadow_time[shadow_cursor] <= it.time_value) begin
          r.fired_handle = shadow_handle[shadow_cursor];
          r.fired        = 1'b1;
          r.last         = 1'b0;
          expected_q.insert(expected_q.size(), r);
          shadow_cursor++;
          n++;
        end
        if (n == 0) begin
          expected_q.insert(expected_q.size(), r);  // nothing due
        end else begin
          r      = expected_q.pop_back();
          r.last = 1'b1;
          expected_q.insert(expected_q.size(), r);
        end
      end
      tedq_pkg::CMD_CLEAR: begin
        shadow_count  = 0;
        shadow_cursor = 0;
        expected_q.insert(expected_q.size(), r);
      end
      default: expected_q.insert(expected_q.size(), r);  // unused code: plain acknowledge
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items; valid is held with a steady payload for
  // as long as the block stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit hold;
    bit go;
    int roll;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) dispatch_command(in_data);
      if (!hold) begin
        go = stim_q.size() != 0;
        // Pressure point: wait for the block to drain before sending on.
        if (go && stim_q[0].drain && expected_q.size() != 0) go = 1'b0;
        if (go) begin
          roll = $urandom_range(0, 99);
          if ((stim_q[0].pace == PACE_SEND_IDLE && roll < 63) ||
              (stim_q[0].pace == PACE_BOTH && roll < 34)) go = 1'b0;
        end
        if (go) begin
          in_data  <= stim_q[0].item;
          in_valid <= 1'b1;
          pace_now <= stim_q[0].pace;
          void'(stim_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure follows the profile of the item last presented.
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      case (pace_now)
        PACE_RECV_STALL: out_stall <= roll < 63;
        PACE_BOTH:       out_stall <= roll < 34;
        default:         out_stall <= 1'b0;
      endcase
    end
  end

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("[%0d] mismatch %s: got 0x%0h, want 0x%0h", cycle_cnt, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: each result transfer is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tedq_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected result", 32'(out_data), '0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.fired_handle !== want.fired_handle)
          log_mismatch("fired_handle", 32'(out_data.fired_handle), 32'(want.fired_handle));
        if (out_data.fired !== want.fired)
          log_mismatch("fired", 32'(out_data.fired), 32'(want.fired));
        if (out_data.status !== want.status)
          log_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.last !== want.last)
          log_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  // Queue one item under the current profile.
  task automatic add_stim(input logic [1:0] cmd, input logic [31:0] tv,
                          input logic [15:0] h);
    stim_t s;
    s.item.cmd        = cmd;
    s.item.time_value = tv;
    s.item.handle     = h;
    s.pace            = gen_pace;
    s.drain           = gen_drain;
    gen_drain         = 1'b0;
    stim_q.insert(stim_q.size(), s);
    gen_items++;
    if (cmd == tedq_pkg::CMD_ADD && gen_entries < tedq_pkg::TABLE_DEPTH) gen_entries++;
    if (cmd == tedq_pkg::CMD_CLEAR) gen_entries = 0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    pace_e last_pace;
    int    pick;
    int    fills;
    int    n;
    int    k;
    int    span;

    // Directed: empty tick, field extremes, equal-time order, repair of an
    // add landing behind the cursor, unused code, clear.
    add_stim(tedq_pkg::CMD_TICK,  32'h0000_0000, 16'h0000);  // nothing in the table
    add_stim(tedq_pkg::CMD_ADD,   32'h8000_0000, 16'hA5A5);
    add_stim(tedq_pkg::CMD_ADD,   32'h0000_0000, 16'h0000);
    add_stim(tedq_pkg::CMD_ADD,   32'hFFFF_FFFF, 16'hFFFF);
    add_stim(tedq_pkg::CMD_ADD,   32'h8000_0000, 16'h5A5A);  // equal time, goes after
    add_stim(tedq_pkg::CMD_ADD,   32'h5555_5555, 16'h5555);
    add_stim(tedq_pkg::CMD_ADD,   32'hAAAA_AAAA, 16'hAAAA);
    add_stim(tedq_pkg::CMD_TICK,  32'h7FFF_FFFF, 16'hFFFF);  // handle field ignored
    add_stim(tedq_pkg::CMD_TICK,  32'h8000_0000, 16'h0000);  // equal time pair, in order
    add_stim(tedq_pkg::CMD_ADD,   32'h0000_0005, 16'h1234);  // lands behind the cursor
    add_stim(tedq_pkg::CMD_TICK,  32'hFFFF_FFFE, 16'h0000);
    add_stim(tedq_pkg::CMD_TICK,  32'hFFFF_FFFF, 16'h0000);  // only the latest fires
    add_stim(tedq_pkg::CMD_TICK,  32'hFFFF_FFFF, 16'h0000);  // nothing left, no refire
    add_stim(CMD_UNUSED,          32'hFFFF_FFFF, 16'hFFFF);
    add_stim(tedq_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    add_stim(tedq_pkg::CMD_TICK,  32'hFFFF_FFFF, 16'h0000);  // cleared table is silent
    add_stim(tedq_pkg::CMD_ADD,   32'h0001_0000, 16'h0001);
    add_stim(tedq_pkg::CMD_TICK,  32'h0000_FFFF, 16'h0000);  // just short of due
    add_stim(tedq_pkg::CMD_TICK,  32'h0001_0000, 16'h0000);  // exactly due
    add_stim(tedq_pkg::CMD_CLEAR, 32'h0000_0000, 16'h0000);

    // Random: mostly sorted-time add bursts followed by ticks, a couple of
    // full-table fills that also fire a maximal tick, and some noise.
    gen_now   = $urandom;
    last_pace = PACE_FREE;
    fills     = 0;
    while (gen_items < ITEM_GOAL) begin
      gen_pace = pace_e'((gen_items / PHASE_LEN) % 4);
      if (gen_pace != last_pace) begin
        gen_drain = 1'b1;
        last_pace = gen_pace;
      end
      pick = $urandom_range(0, 19);
      if ((fills == 0 || pick == 0) && fills < 2) begin
        // Fill to the brim, try to overfill, then fire everything at once.
        fills++;
        add_stim(tedq_pkg::CMD_CLEAR, $urandom, rand_handle());
        for (k = 0; k < tedq_pkg::TABLE_DEPTH; k++)
          add_stim(tedq_pkg::CMD_ADD, gen_now + $urandom_range(0, 200), rand_handle());
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          add_stim(tedq_pkg::CMD_ADD, $urandom, rand_handle());
        add_stim(tedq_pkg::CMD_TICK, 32'hFFFF_FFFF, rand_handle());
        add_stim(tedq_pkg::CMD_TICK, 32'hFFFF_FFFF, rand_handle());
        add_stim(tedq_pkg::CMD_CLEAR, $urandom, rand_handle());
      end else if (pick < 3) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          add_stim(2'($urandom_range(0, 3)), $urandom, rand_handle());
      end else begin
        if (gen_entries > 48 && $urandom_range(0, 3) != 0) begin
          add_stim(tedq_pkg::CMD_CLEAR, $urandom, rand_handle());
          gen_now = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1000);
        end
        case ($urandom_range(0, 3))
          0:       span = 0;     // many equal due times
          1:       span = 4;
          2:       span = 300;
          default: span = 70000;
        endcase
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 4) == 0)
            add_stim(tedq_pkg::CMD_ADD, gen_now - $urandom_range(0, 16), rand_handle());
          else
            add_stim(tedq_pkg::CMD_ADD, gen_now + $urandom_range(0, span), rand_handle());
        end
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          gen_now = gen_now + $urandom_range(0, span);
          add_stim(tedq_pkg::CMD_TICK, gen_now, rand_handle());
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the driving edge so the queues are settled.
    while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("timed_event_dispatch_queue_core regression: pass");
    end else begin
      $display("timed_event_dispatch_queue_core regression: fail");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timed_event_dispatch_queue_core regression: fail");
    $finish;
  end

endmodule
